### rtl/scsc_pkg.sv
// ----------------------------------------------------------------------------
// scsc_pkg
// Types, codes and mode tables shared by the servo command slew controller.
// ----------------------------------------------------------------------------
package scsc_pkg;

  typedef enum logic [2:0] {
    MODE_DISARMED = 3'd0,
    MODE_ARMED    = 3'd1,
    MODE_TAKEOFF  = 3'd2,
    MODE_CRUISE   = 3'd3,
    MODE_LANDING  = 3'd4,
    MODE_FAILSAFE = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    DIR_POS = 2'd0,
    DIR_NEG = 2'd1,
    DIR_CTR = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    MOVE_NONE = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_t;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_HOLD  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINK_LOSS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_LOW  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_HIGH = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SERVO_CTR  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLAP_LEFT  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_FLAP_RIGHT = 3'd6;

  localparam logic [7:0] KEY_ROLL_POS  = 8'h61;  // a
  localparam logic [7:0] KEY_ROLL_NEG  = 8'h64;  // d
  localparam logic [7:0] KEY_PITCH_POS = 8'h77;  // w
  localparam logic [7:0] KEY_PITCH_NEG = 8'h73;  // s
  localparam logic [7:0] KEY_YAW_POS   = 8'h6C;  // l
  localparam logic [7:0] KEY_YAW_NEG   = 8'h6A;  // j
  localparam logic [7:0] KEY_ARMED     = 8'h70;  // p
  localparam logic [7:0] KEY_LANDING   = 8'h6F;  // o
  localparam logic [7:0] KEY_TAKEOFF   = 8'h69;  // i
  localparam logic [7:0] KEY_CRUISE    = 8'h75;  // u
  localparam logic [7:0] KEY_DISARMED  = 8'h20;  // space

  localparam int unsigned CH_LEFT  = 0;
  localparam int unsigned CH_RIGHT = 1;
  localparam int unsigned CH_ELEV  = 2;
  localparam int unsigned CH_RUDD  = 3;
  localparam int unsigned CH_MOTOR = 4;

  typedef struct packed {
    logic [15:0] axis_hold_ms;
    logic [19:0] link_loss_ms;
    logic [15:0] servo_low;
    logic [15:0] servo_high;
    logic [15:0] servo_center;
    logic [15:0] flap_left_rest;
    logic [15:0] flap_right_rest;
  } cfg_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  key;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] left_aileron_pulse;
    logic [15:0] right_aileron_pulse;
    logic [15:0] elevator_pulse;
    logic [15:0] rudder_pulse;
    logic [15:0] motor_pulse;
    logic [2:0]  flight_mode;
    logic        outputs_updated;
  } res_t;

  typedef struct packed {
    mode_t             mode;
    dir_t              roll_dir;
    dir_t              pitch_dir;
    dir_t              yaw_dir;
    logic [31:0]       roll_stamp;
    logic [31:0]       pitch_stamp;
    logic [31:0]       yaw_stamp;
    logic [31:0]       link_stamp;
    logic [5:0]        step_size;
    logic [10:0]       motor_duty;
    logic [3:0][15:0]  surface;
    logic [3:0][15:0]  rest;
    logic [4:0][15:0]  latched;
  } state_t;

  localparam cfg_t CFG_RESET = '{
    axis_hold_ms:    16'd150,
    link_loss_ms:    20'd8000,
    servo_low:       16'd1000,
    servo_high:      16'd2000,
    servo_center:    16'd1500,
    flap_left_rest:  16'd1700,
    flap_right_rest: 16'd1300
  };

  localparam state_t STATE_RESET = '{
    mode:        MODE_DISARMED,
    roll_dir:    DIR_CTR,
    pitch_dir:   DIR_CTR,
    yaw_dir:     DIR_CTR,
    roll_stamp:  32'd0,
    pitch_stamp: 32'd0,
    yaw_stamp:   32'd0,
    link_stamp:  32'd0,
    step_size:   6'd50,
    motor_duty:  11'd1000,
    surface:     {4{16'd1500}},
    rest:        {4{16'd0}},
    latched:     {16'd1000, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  function automatic logic [5:0] mode_step(input mode_t m, input logic [5:0] cur);
    case (m)
      MODE_DISARMED: mode_step = 6'd50;
      MODE_ARMED:    mode_step = 6'd50;
      MODE_TAKEOFF:  mode_step = 6'd50;
      MODE_CRUISE:   mode_step = 6'd20;
      MODE_LANDING:  mode_step = 6'd25;
      MODE_FAILSAFE: mode_step = 6'd20;
      default:       mode_step = cur;
    endcase
  endfunction

  function automatic logic [10:0] mode_motor(input mode_t m, input logic [10:0] cur);
    case (m)
      MODE_DISARMED: mode_motor = 11'd1000;
      MODE_ARMED:    mode_motor = 11'd1000;
      MODE_TAKEOFF:  mode_motor = 11'd2000;
      MODE_CRUISE:   mode_motor = 11'd1550;
      MODE_LANDING:  mode_motor = 11'd1200;
      MODE_FAILSAFE: mode_motor = 11'd1000;
      default:       mode_motor = cur;
    endcase
  endfunction

endpackage

### rtl/scsc_stream_if.sv
// ----------------------------------------------------------------------------
// scsc_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface scsc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/scsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// scsc_cfg_regs
// Configuration register file: limits, rest pulses and timeouts.
// ----------------------------------------------------------------------------
module scsc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [scsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [scsc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output scsc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= scsc_pkg::CFG_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        scsc_pkg::CFG_AXIS_HOLD:  cfg.axis_hold_ms    <= cfg_data[15:0];
        scsc_pkg::CFG_LINK_LOSS:  cfg.link_loss_ms    <= cfg_data[19:0];
        scsc_pkg::CFG_SERVO_LOW:  cfg.servo_low       <= cfg_data[15:0];
        scsc_pkg::CFG_SERVO_HIGH: cfg.servo_high      <= cfg_data[15:0];
        scsc_pkg::CFG_SERVO_CTR:  cfg.servo_center    <= cfg_data[15:0];
        scsc_pkg::CFG_FLAP_LEFT:  cfg.flap_left_rest  <= cfg_data[15:0];
        scsc_pkg::CFG_FLAP_RIGHT: cfg.flap_right_rest <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/scsc_step_logic.sv
// ----------------------------------------------------------------------------
// scsc_step_logic
// Next-state logic for one command byte or one update tick.
// ----------------------------------------------------------------------------
module scsc_step_logic (
  input  scsc_pkg::cfg_t   cfg,
  input  scsc_pkg::state_t st,
  input  scsc_pkg::cmd_t   cmd,
  output scsc_pkg::state_t st_next,
  output logic             updated
);

  function automatic scsc_pkg::move_t slew_move(
    input scsc_pkg::dir_t d,
    input logic [15:0]    probe,
    input logic [15:0]    rest_val,
    input logic [15:0]    lo,
    input logic [15:0]    hi
  );
    case (d)
      scsc_pkg::DIR_POS:
        slew_move = (probe < hi) ? scsc_pkg::MOVE_UP : scsc_pkg::MOVE_NONE;
      scsc_pkg::DIR_NEG:
        slew_move = (probe > lo) ? scsc_pkg::MOVE_DOWN : scsc_pkg::MOVE_NONE;
      default: begin
        if (probe > rest_val) slew_move = scsc_pkg::MOVE_DOWN;
        else if (probe < rest_val) slew_move = scsc_pkg::MOVE_UP;
        else slew_move = scsc_pkg::MOVE_NONE;
      end
    endcase
  endfunction

  function automatic logic [15:0] apply_move(
    input logic [15:0]     p,
    input scsc_pkg::move_t mv,
    input logic [5:0]      step
  );
    case (mv)
      scsc_pkg::MOVE_UP:   apply_move = p + {10'd0, step};
      scsc_pkg::MOVE_DOWN: apply_move = p - {10'd0, step};
      default:             apply_move = p;
    endcase
  endfunction

  always_comb begin
    scsc_pkg::state_t n;
    scsc_pkg::move_t  mv_roll;
    scsc_pkg::move_t  mv_pitch;
    scsc_pkg::move_t  mv_yaw;
    logic [31:0]      age_roll;
    logic [31:0]      age_pitch;
    logic [31:0]      age_yaw;
    logic [31:0]      age_link;
    logic [31:0]      hold;

    n         = st;
    updated   = 1'b0;
    age_roll  = cmd.now_ms - st.roll_stamp;
    age_pitch = cmd.now_ms - st.pitch_stamp;
    age_yaw   = cmd.now_ms - st.yaw_stamp;
    age_link  = cmd.now_ms - st.link_stamp;
    hold      = {16'd0, cfg.axis_hold_ms};
    mv_roll   = scsc_pkg::MOVE_NONE;
    mv_pitch  = scsc_pkg::MOVE_NONE;
    mv_yaw    = scsc_pkg::MOVE_NONE;

    if (!cmd.op) begin
      n.link_stamp = cmd.now_ms;
      case (cmd.key)
        scsc_pkg::KEY_ROLL_POS: begin
          n.roll_dir = scsc_pkg::DIR_POS; n.roll_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_ROLL_NEG: begin
          n.roll_dir = scsc_pkg::DIR_NEG; n.roll_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_PITCH_POS: begin
          n.pitch_dir = scsc_pkg::DIR_POS; n.pitch_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_PITCH_NEG: begin
          n.pitch_dir = scsc_pkg::DIR_NEG; n.pitch_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_YAW_POS: begin
          n.yaw_dir = scsc_pkg::DIR_POS; n.yaw_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_YAW_NEG: begin
          n.yaw_dir = scsc_pkg::DIR_NEG; n.yaw_stamp = cmd.now_ms;
        end
        scsc_pkg::KEY_ARMED:    n.mode = scsc_pkg::MODE_ARMED;
        scsc_pkg::KEY_LANDING:  n.mode = scsc_pkg::MODE_LANDING;
        scsc_pkg::KEY_TAKEOFF:  n.mode = scsc_pkg::MODE_TAKEOFF;
        scsc_pkg::KEY_CRUISE:   n.mode = scsc_pkg::MODE_CRUISE;
        scsc_pkg::KEY_DISARMED: n.mode = scsc_pkg::MODE_DISARMED;
        default: ;
      endcase
      n.step_size  = scsc_pkg::mode_step(n.mode, st.step_size);
      n.motor_duty = scsc_pkg::mode_motor(n.mode, st.motor_duty);
    end else begin
      if (age_pitch > hold) n.pitch_dir = scsc_pkg::DIR_CTR;
      if (age_roll > hold) n.roll_dir = scsc_pkg::DIR_CTR;
      if (age_yaw > hold) n.yaw_dir = scsc_pkg::DIR_CTR;
      if (age_link > {12'd0, cfg.link_loss_ms}) n.mode = scsc_pkg::MODE_FAILSAFE;

      case (n.mode)
        scsc_pkg::MODE_DISARMED, scsc_pkg::MODE_ARMED, scsc_pkg::MODE_CRUISE: begin
          n.rest = {4{cfg.servo_center}};
        end
        scsc_pkg::MODE_TAKEOFF, scsc_pkg::MODE_LANDING: begin
          n.roll_dir = scsc_pkg::DIR_CTR;
          n.rest[scsc_pkg::CH_LEFT]  = cfg.flap_left_rest;
          n.rest[scsc_pkg::CH_RIGHT] = cfg.flap_right_rest;
        end
        scsc_pkg::MODE_FAILSAFE: begin
          n.roll_dir  = scsc_pkg::DIR_CTR;
          n.pitch_dir = scsc_pkg::DIR_CTR;
          n.yaw_dir   = scsc_pkg::DIR_CTR;
          n.rest      = {4{cfg.servo_center}};
        end
        default: ;
      endcase

      // right aileron alone steers both ailerons
      mv_roll  = slew_move(n.roll_dir, st.surface[scsc_pkg::CH_RIGHT],
                           n.rest[scsc_pkg::CH_RIGHT], cfg.servo_low, cfg.servo_high);
      mv_pitch = slew_move(n.pitch_dir, st.surface[scsc_pkg::CH_ELEV],
                           n.rest[scsc_pkg::CH_ELEV], cfg.servo_low, cfg.servo_high);
      mv_yaw   = slew_move(n.yaw_dir, st.surface[scsc_pkg::CH_RUDD],
                           n.rest[scsc_pkg::CH_RUDD], cfg.servo_low, cfg.servo_high);
      n.surface[scsc_pkg::CH_LEFT]  =
        apply_move(st.surface[scsc_pkg::CH_LEFT], mv_roll, st.step_size);
      n.surface[scsc_pkg::CH_RIGHT] =
        apply_move(st.surface[scsc_pkg::CH_RIGHT], mv_roll, st.step_size);
      n.surface[scsc_pkg::CH_ELEV]  =
        apply_move(st.surface[scsc_pkg::CH_ELEV], mv_pitch, st.step_size);
      n.surface[scsc_pkg::CH_RUDD]  =
        apply_move(st.surface[scsc_pkg::CH_RUDD], mv_yaw, st.step_size);

      updated = 1'b1;
      case (n.mode)
        scsc_pkg::MODE_DISARMED, scsc_pkg::MODE_ARMED, scsc_pkg::MODE_CRUISE: begin
          n.latched[3:0] = n.surface;
        end
        scsc_pkg::MODE_TAKEOFF, scsc_pkg::MODE_LANDING: begin
          n.latched[scsc_pkg::CH_LEFT]  = n.rest[scsc_pkg::CH_LEFT];
          n.latched[scsc_pkg::CH_RIGHT] = n.rest[scsc_pkg::CH_RIGHT];
          n.latched[scsc_pkg::CH_ELEV]  = n.surface[scsc_pkg::CH_ELEV];
          n.latched[scsc_pkg::CH_RUDD]  = n.surface[scsc_pkg::CH_RUDD];
        end
        scsc_pkg::MODE_FAILSAFE: begin
          n.latched[3:0] = n.rest;
        end
        default: updated = 1'b0;
      endcase
      if (updated) n.latched[scsc_pkg::CH_MOTOR] = {5'd0, st.motor_duty};
    end

    st_next = n;
  end

endmodule

### rtl/servo_command_slew_controller_core.sv
// ----------------------------------------------------------------------------
// servo_command_slew_controller_core
// Servo command slew controller: command bytes set axis directions and
// flight mode, update ticks slew the surface pulses and latch the channels.
// ----------------------------------------------------------------------------
// Result is registered: valid in the cycle after the input transfer.
// Throughput: 1 item per cycle unless a pending result is held by !res.ready; the state registers close the only loop.
// Output register frees while it is read, so input ready = !valid || ready.
// Reset (rst, synchronous): mode disarmed, surfaces 1500, latched pulses
// 0 with motor 1000, configuration registers at their default values.
// ----------------------------------------------------------------------------
module servo_command_slew_controller_core (
  input  logic                             clk,
  input  logic                             rst,
  scsc_stream_if.sink                      cmd,
  scsc_stream_if.source                    res,
  input  logic                             cfg_write,
  input  logic [scsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  scsc_pkg::cfg_t   cfg;
  scsc_pkg::state_t st;
  scsc_pkg::state_t st_next;
  scsc_pkg::cmd_t   cmd_item;
  scsc_pkg::res_t   res_item;
  logic             updated_next;
  logic             updated;
  logic             res_valid;
  logic             cmd_xfer;

  scsc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cmd_item = cmd.payload;

  scsc_step_logic u_step_logic (
    .cfg     (cfg),
    .st      (st),
    .cmd     (cmd_item),
    .st_next (st_next),
    .updated (updated_next)
  );

  assign cmd.ready = !res_valid || res.ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= scsc_pkg::STATE_RESET;
      updated   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cmd_xfer) begin
        st      <= st_next;
        updated <= updated_next;
      end
      if (cmd_xfer) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
    end
  end

  // latched state doubles as the result payload; it only moves on a transfer
  always_comb begin
    res_item.left_aileron_pulse  = st.latched[scsc_pkg::CH_LEFT];
    res_item.right_aileron_pulse = st.latched[scsc_pkg::CH_RIGHT];
    res_item.elevator_pulse      = st.latched[scsc_pkg::CH_ELEV];
    res_item.rudder_pulse        = st.latched[scsc_pkg::CH_RUDD];
    res_item.motor_pulse         = st.latched[scsc_pkg::CH_MOTOR];
    res_item.flight_mode         = st.mode;
    res_item.outputs_updated     = updated;
  end

  assign res.valid   = res_valid;
  assign res.payload = res_item;

endmodule
